@@ design/ghcw_pkg.sv @@
// Shared types and constants for the greedy hill-climb walk block.
// No dependencies; the design files take names from here by scope, the testbench imports it.
package ghcw_pkg;

    localparam int NODES      = 16;
    localparam int NODE_W     = 4;
    localparam int ROW_W      = 16;
    localparam int HEUR_W     = 16;
    localparam int VAL_W      = HEUR_W + 1;
    localparam int SCAN_LIMIT = (NODES < ROW_W) ? NODES : ROW_W;
    localparam int CAND_W     = NODE_W + 1;

    localparam logic [CAND_W-1:0]       NO_CANDIDATE = CAND_W'(ROW_W);
    localparam logic signed [VAL_W-1:0] ABOVE_RANGE  = VAL_W'(32'sd32768);
    localparam logic [NODE_W-1:0]       SCAN_LAST    = NODE_W'(SCAN_LIMIT - 1);

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_GOAL     = 2'd1,
        ST_STUCK    = 2'd2
    } status_t;

    // Memory port requests from the walk controller
    typedef struct packed {
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_row;
        logic [HEUR_W-1:0] wr_heur;
        logic [NODE_W-1:0] rd_addr;
    } mem_req_t;

    // Registered read data for the rd_addr presented in the previous cycle
    typedef struct packed {
        logic [ROW_W-1:0]  rd_row;
        logic [HEUR_W-1:0] rd_heur;
    } mem_rsp_t;

endpackage

@@ design/ghcw_item_if.sv @@
// Input channel of the hill-climb walk: load and run transactions.
// Depends on ghcw_pkg for field widths.
interface ghcw_item_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [ghcw_pkg::NODE_W-1:0]        node_index;
    logic [ghcw_pkg::ROW_W-1:0]         row_edges;
    logic signed [ghcw_pkg::HEUR_W-1:0] node_heuristic;
    logic [ghcw_pkg::NODE_W-1:0]        start_node;
    logic [ghcw_pkg::NODE_W-1:0]        goal_node;

    modport source (output valid, op, node_index, row_edges, node_heuristic,
                    start_node, goal_node, input ready);
    modport sink   (input valid, op, node_index, row_edges, node_heuristic,
                    start_node, goal_node, output ready);
endinterface

@@ design/ghcw_result_if.sv @@
// Output channel of the hill-climb walk: one transaction per path node.
// Depends on ghcw_pkg for field widths.
interface ghcw_result_if;
    logic                               valid;
    logic                               ready;
    logic [ghcw_pkg::NODE_W-1:0]        path_node;
    logic signed [ghcw_pkg::HEUR_W-1:0] path_heuristic;
    logic [1:0]                         walk_status;
    logic                               last;

    modport source (output valid, path_node, path_heuristic, walk_status, last,
                    input ready);
    modport sink   (input valid, path_node, path_heuristic, walk_status, last,
                    output ready);
endinterface

@@ design/ghcw_store.sv @@
// Node store: adjacency row memory and heuristic memory, one write port
// and one registered read port each. Depends on ghcw_pkg.
module ghcw_store (
    input  logic               clk,
    input  ghcw_pkg::mem_req_t req,
    output ghcw_pkg::mem_rsp_t rsp
);

    logic [ghcw_pkg::ROW_W-1:0]  adj_mem  [ghcw_pkg::NODES];
    logic [ghcw_pkg::HEUR_W-1:0] heur_mem [ghcw_pkg::NODES];

    logic [ghcw_pkg::ROW_W-1:0]  rd_row_reg;
    logic [ghcw_pkg::HEUR_W-1:0] rd_heur_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            adj_mem[req.wr_addr]  <= req.wr_row;
            heur_mem[req.wr_addr] <= req.wr_heur;
        end
        rd_row_reg  <= adj_mem[req.rd_addr];
        rd_heur_reg <= heur_mem[req.rd_addr];
    end

    assign rsp.rd_row  = rd_row_reg;
    assign rsp.rd_heur = rd_heur_reg;

endmodule

@@ design/ghcw_walk.sv @@
// Walk controller: takes load/run transactions, scans neighbors through the
// node store one per cycle, and holds the result register. Depends on ghcw_pkg
// and the two channel interfaces.
module ghcw_walk (
    input  logic               clk,
    input  logic               rst_n,
    ghcw_item_if.sink          item,
    ghcw_result_if.source      result,
    output ghcw_pkg::mem_req_t req,
    input  ghcw_pkg::mem_rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE
    } state_t;

    state_t                              state_reg;
    logic [ghcw_pkg::NODE_W-1:0]         cur_reg;
    logic [ghcw_pkg::NODE_W-1:0]         goal_reg;
    logic [ghcw_pkg::ROW_W-1:0]          row_reg;
    logic [ghcw_pkg::HEUR_W-1:0]         cur_heur_reg;
    logic [ghcw_pkg::NODES-1:0]          visited_reg;
    logic [ghcw_pkg::NODE_W-1:0]         scan_idx_reg;
    logic                                cmp_valid_reg;
    logic [ghcw_pkg::NODE_W-1:0]         cmp_idx_reg;
    logic [ghcw_pkg::CAND_W-1:0]         best_cand_reg;
    logic signed [ghcw_pkg::VAL_W-1:0]   best_val_reg;

    logic                                out_valid_reg;
    logic [ghcw_pkg::NODE_W-1:0]         out_node_reg;
    logic [ghcw_pkg::HEUR_W-1:0]         out_heur_reg;
    ghcw_pkg::status_t                   out_status_reg;
    logic                                out_last_reg;

    logic                                accept;
    logic                                out_free;
    logic                                out_load;
    logic                                in_range;
    logic signed [ghcw_pkg::VAL_W-1:0]   cand_val;
    logic                                cand_better;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = out_free && (((state_reg == S_CHECK) && (cur_reg == goal_reg))
                                     || (state_reg == S_DECIDE));
    assign in_range   = ({1'b0, item.start_node} < ghcw_pkg::CAND_W'(ghcw_pkg::NODES))
                     && ({1'b0, item.goal_node} < ghcw_pkg::CAND_W'(ghcw_pkg::NODES));

    assign cand_val    = {rsp.rd_heur[ghcw_pkg::HEUR_W-1], rsp.rd_heur};
    assign cand_better = row_reg[cmp_idx_reg] && !visited_reg[cmp_idx_reg]
                      && (cand_val < best_val_reg);

    always_comb
    begin
        req.wr_en   = accept && (item.op == ghcw_pkg::OP_LOAD)
                   && ({1'b0, item.node_index} < ghcw_pkg::CAND_W'(ghcw_pkg::NODES));
        req.wr_addr = item.node_index;
        req.wr_row  = item.row_edges;
        req.wr_heur = item.node_heuristic;
        req.rd_addr = (state_reg == S_SCAN) ? scan_idx_reg : cur_reg;
    end

    assign result.valid          = out_valid_reg;
    assign result.path_node      = out_node_reg;
    assign result.path_heuristic = out_heur_reg;
    assign result.walk_status    = out_status_reg;
    assign result.last           = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            goal_reg       <= '0;
            row_reg        <= '0;
            cur_heur_reg   <= '0;
            visited_reg    <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            best_cand_reg  <= ghcw_pkg::NO_CANDIDATE;
            best_val_reg   <= ghcw_pkg::ABOVE_RANGE;
            out_valid_reg  <= 1'b0;
            out_node_reg   <= '0;
            out_heur_reg   <= '0;
            out_status_reg <= ghcw_pkg::ST_CONTINUE;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // drain the result register once the sink takes it, unless a new one loads
            if (result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            // compare stage: heuristic of cmp_idx_reg arrives this cycle
            cmp_valid_reg <= (state_reg == S_SCAN);
            cmp_idx_reg   <= scan_idx_reg;
            if (cmp_valid_reg && cand_better)
            begin
                best_val_reg  <= cand_val;
                best_cand_reg <= {1'b0, cmp_idx_reg};
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (item.op == ghcw_pkg::OP_RUN) && in_range)
                    begin
                        cur_reg     <= item.start_node;
                        goal_reg    <= item.goal_node;
                        visited_reg <= '0;
                        state_reg   <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LATCH;
                end
                S_LATCH:
                begin
                    row_reg      <= rsp.rd_row;
                    cur_heur_reg <= rsp.rd_heur;
                    state_reg    <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (cur_reg == goal_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_node_reg   <= cur_reg;
                            out_heur_reg   <= cur_heur_reg;
                            out_status_reg <= ghcw_pkg::ST_GOAL;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        visited_reg[cur_reg] <= 1'b1;
                        scan_idx_reg         <= '0;
                        best_cand_reg        <= ghcw_pkg::NO_CANDIDATE;
                        best_val_reg         <= ghcw_pkg::ABOVE_RANGE;
                        state_reg            <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_idx_reg == ghcw_pkg::SCAN_LAST)
                    begin
                        state_reg <= S_SCAN_END;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_SCAN_END:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_node_reg  <= cur_reg;
                        out_heur_reg  <= cur_heur_reg;
                        if (best_cand_reg == ghcw_pkg::NO_CANDIDATE)
                        begin
                            out_status_reg <= ghcw_pkg::ST_STUCK;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            out_status_reg <= ghcw_pkg::ST_CONTINUE;
                            out_last_reg   <= 1'b0;
                            // advance to the best neighbor and fetch its row
                            cur_reg        <= best_cand_reg[ghcw_pkg::NODE_W-1:0];
                            cur_heur_reg   <= best_val_reg[ghcw_pkg::HEUR_W-1:0];
                            state_reg      <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/greedy_hill_climb_walk_top.sv @@
// Channel     | Dir | Transaction
// item        | in  | op=load: store node row/heuristic; op=run: walk start->goal
// result      | out | one path node with heuristic, status and last flag
//
// A load is written to the node store when it is accepted. A run is accepted,
// then each path node passes S_READ and S_LATCH to fetch its row, S_CHECK, S_SCAN
// to read one neighbor heuristic per cycle through the single read port, and
// S_SCAN_END and S_DECIDE to settle and decide; a final goal node ends at S_CHECK.
// Reset clears control state only; the node memories hold garbage until loaded.
// A stalled result holds the walk in place; no new transaction is taken
// until the last result of a run is in the result register.
// Depends on ghcw_pkg, ghcw_item_if, ghcw_result_if, ghcw_store, ghcw_walk.
module greedy_hill_climb_walk_top (
    input  logic          clk,
    input  logic          rst_n,
    ghcw_item_if.sink     item,
    ghcw_result_if.source result
);

    ghcw_pkg::mem_req_t mem_req;
    ghcw_pkg::mem_rsp_t mem_rsp;

    ghcw_store u_store (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    ghcw_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .req    (mem_req),
        .rsp    (mem_rsp)
    );

endmodule

@@ tb/tb_greedy_hill_climb_walk_top.sv @@
// Self-checking testbench for greedy_hill_climb_walk_top: node loads and greedy walks,
// every path transaction checked against a planned step or an in-bench walk predictor.
// Depends on ghcw_pkg, ghcw_item_if, ghcw_result_if and the block itself.
module tb_greedy_hill_climb_walk_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ghcw_pkg::*;

    localparam int RANDOM_ITEMS = 185;
    localparam int QUIET_TAIL   = 40;
    localparam int PAUSE_AT     = 90;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN        = 400;
    localparam int IDLE_LIMIT   = 4000;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] node_index;
        logic [ROW_W-1:0]  row_edges;
        logic [HEUR_W-1:0] node_heuristic;
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] goal_node;
    } walk_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] path_node;
        logic [HEUR_W-1:0] path_heuristic;
        logic [1:0]        walk_status;
        logic              last;
    } path_step_t;

    typedef struct packed {
        walk_item_t item;
        logic       typed;
        path_step_t want;
    } plan_row_t;

    localparam path_step_t NO_STEP  = '0;
    localparam int         PLAN_LEN = 25;

    // Load the whole graph first so no walk ever reads an unwritten node.
    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        '{'{OP_LOAD, 4'd0,  16'hFFFF, 16'h0000, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd1,  16'h0000, 16'h8000, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd2,  16'h0005, 16'h7FFF, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd3,  16'h0018, 16'h0005, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd4,  16'h0028, 16'h0005, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd5,  16'h0018, 16'h0005, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd6,  16'h8000, 16'hFFFF, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd7,  16'h0040, 16'h0001, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd8,  16'h0200, 16'h0002, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd9,  16'h0400, 16'h0003, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd10, 16'h0800, 16'h0004, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd11, 16'h1000, 16'h0006, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd12, 16'h2000, 16'h0007, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd13, 16'h4000, 16'h0008, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd14, 16'h8000, 16'h0009, 4'd0, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_LOAD, 4'd15, 16'h0100, 16'h7FFE, 4'd0, 4'd0}, 1'b0, NO_STEP},
        // start equals goal: the goal alone
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd7, 4'd7}, 1'b1,
          '{4'd7, 16'h0001, ST_GOAL, 1'b1}},
        // start on a node with no edges
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd1, 4'd0}, 1'b1,
          '{4'd1, 16'h8000, ST_STUCK, 1'b1}},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd0, 4'd15}, 1'b0, NO_STEP},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd8, 4'd15}, 1'b0, NO_STEP},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd15, 4'd2}, 1'b0, NO_STEP},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd5, 4'd2}, 1'b0, NO_STEP},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd2, 4'd0}, 1'b0, NO_STEP},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd6, 4'd1}, 1'b0, NO_STEP},
        '{'{OP_RUN, 4'd0, 16'h0000, 16'h0000, 4'd0, 4'd1}, 1'b0, NO_STEP}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ghcw_item_if   item_ch ();
    ghcw_result_if result_ch ();

    greedy_hill_climb_walk_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always #1 clk = ~clk;

    // Predictor state
    logic [ROW_W-1:0]         row_mem  [NODES];
    logic signed [HEUR_W-1:0] heur_mem [NODES];
    path_step_t               expected_path [$];

    int errors      = 0;
    int loads_sent  = 0;
    int walks_sent  = 0;
    int steps_seen  = 0;
    int goals_seen  = 0;
    int stucks_seen = 0;
    int sender_rate;
    bit quiet_tail;
    bit long_hold_done;
    int idle_cycles = 0;

    function automatic void queue_step(path_step_t s);
        expected_path.insert(expected_path.size(), s);
    endfunction

    function automatic path_step_t make_step(logic [NODE_W-1:0] node, logic [1:0] status,
                                             logic is_last);
        path_step_t s;
        s.path_node      = node;
        s.path_heuristic = heur_mem[node];
        s.walk_status    = status;
        s.last           = is_last;
        return s;
    endfunction

    function automatic void predict_walk(logic [NODE_W-1:0] start, logic [NODE_W-1:0] goal);
        logic [NODE_W-1:0] cur;
        logic [NODES-1:0]  visited;
        int                best;
        int                best_val;
        cur     = start;
        visited = '0;
        while (cur != goal)
        begin
            visited[cur] = 1'b1;
            best         = -1;
            best_val     = 32768;
            for (int j = 0; j < SCAN_LIMIT; j++)
            begin
                if (row_mem[cur][j] && !visited[j] && int'(heur_mem[j]) < best_val)
                begin
                    best_val = int'(heur_mem[j]);
                    best     = j;
                end
            end
            if (best < 0)
            begin
                queue_step(make_step(cur, ST_STUCK, 1'b1));
                return;
            end
            queue_step(make_step(cur, ST_CONTINUE, 1'b0));
            cur = NODE_W'(best);
        end
        queue_step(make_step(cur, ST_GOAL, 1'b1));
    endfunction

    function automatic walk_item_t random_item();
        walk_item_t it;
        it.op             = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_RUN;
        it.node_index     = NODE_W'($urandom);
        it.row_edges      = ROW_W'($urandom);
        it.node_heuristic = HEUR_W'($urandom);
        it.start_node     = NODE_W'($urandom);
        it.goal_node      = NODE_W'($urandom);
        if (it.op == OP_LOAD)
        begin
            case ($urandom_range(0, 3))
                0: it.row_edges = ROW_W'(($urandom_range(0, 1) << $urandom_range(0, 15))
                                        | (1 << $urandom_range(0, 15)));
                1: it.row_edges = ROW_W'($urandom | $urandom);
                2: it.row_edges = ROW_W'($urandom & $urandom);
                default: ;
            endcase
            case ($urandom_range(0, 3))
                // narrow range to force ties
                2: it.node_heuristic = HEUR_W'($urandom_range(0, 6) - 3);
                3: it.node_heuristic = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic send_item(walk_item_t it, logic typed, path_step_t want);
        int idle;
        if (!quiet_tail && sender_rate != 0 &&
            $urandom_range(0, (sender_rate == 1) ? 3 : 1) == 0)
        begin
            idle = $urandom_range(1, 7);
            @(negedge clk);
            item_ch.valid = 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid          = 1'b1;
        item_ch.op             = it.op;
        item_ch.node_index     = it.node_index;
        item_ch.row_edges      = it.row_edges;
        item_ch.node_heuristic = it.node_heuristic;
        item_ch.start_node     = it.start_node;
        item_ch.goal_node      = it.goal_node;
        do @(posedge clk); while (!item_ch.ready);
        if (it.op == OP_LOAD)
        begin
            row_mem[it.node_index]  = it.row_edges;
            heur_mem[it.node_index] = it.node_heuristic;
            loads_sent++;
        end
        else
        begin
            walks_sent++;
            if (typed)
                queue_step(want);
            else
                predict_walk(it.start_node, it.goal_node);
        end
    endtask

    // Stimulus
    initial
    begin
        item_ch.valid          = 1'b0;
        item_ch.op             = OP_LOAD;
        item_ch.node_index     = '0;
        item_ch.row_edges      = '0;
        item_ch.node_heuristic = '0;
        item_ch.start_node     = '0;
        item_ch.goal_node      = '0;
        sender_rate            = 0;
        quiet_tail             = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
            send_item(PLAN[i].item, PLAN[i].typed, PLAN[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sender_rate = (i / 30) % 3;
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
                quiet_tail = 1'b1;
            if (i == PAUSE_AT)
            begin
                // hold off until every outstanding path transaction is back
                @(negedge clk);
                item_ch.valid = 1'b0;
                while (expected_path.size() != 0) @(posedge clk);
            end
            send_item(random_item(), 1'b0, NO_STEP);
        end

        @(negedge clk);
        item_ch.valid = 1'b0;
        while (expected_path.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d node loads and %0d walks; checked %0d path transactions,",
                 loads_sent, walks_sent, steps_seen);
        $display("%0d walks ended at the goal and %0d at a dead end.", goals_seen, stucks_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result sink: random stall bursts plus one long hold to back up the input
    initial
    begin
        int stall_left;
        int mode;
        bit stall;
        stall_left         = 0;
        long_hold_done     = 1'b0;
        result_ch.ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            mode  = (steps_seen / 40) % 3;
            stall = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                stall = 1'b1;
            end
            else if (!long_hold_done && steps_seen >= 60)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD - 1;
                stall          = 1'b1;
            end
            else if (!quiet_tail && mode != 0 &&
                     $urandom_range(0, (mode == 1) ? 7 : 2) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                stall      = 1'b1;
            end
            result_ch.ready = !stall;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        path_step_t got;
        path_step_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.path_node      = result_ch.path_node;
            got.path_heuristic = result_ch.path_heuristic;
            got.walk_status    = result_ch.walk_status;
            got.last           = result_ch.last;
            steps_seen++;
            if (got.last && got.walk_status == ST_GOAL)
                goals_seen++;
            if (got.last && got.walk_status == ST_STUCK)
                stucks_seen++;
            if (expected_path.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected path transaction: node %0d heur %0d status %0d last %0d",
                         $realtime, got.path_node, $signed(got.path_heuristic),
                         got.walk_status, got.last);
            end
            else
            begin
                want = expected_path.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: path mismatch: expected node %0d heur %0d status %0d last %0d",
                             $realtime, want.path_node, $signed(want.path_heuristic),
                             want.walk_status, want.last);
                    $display("%0t:                got      node %0d heur %0d status %0d last %0d",
                             $realtime, got.path_node, $signed(got.path_heuristic),
                             got.walk_status, got.last);
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles at %0t", IDLE_LIMIT, $realtime);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ greedy_hill_climb_walk_top.f @@
design/ghcw_pkg.sv
design/ghcw_item_if.sv
design/ghcw_result_if.sv
design/ghcw_store.sv
design/ghcw_walk.sv
design/greedy_hill_climb_walk_top.sv
tb/tb_greedy_hill_climb_walk_top.sv
